/* sv/abls_pkg.sv */
// ----------------------------------------------------------------------------
// abls_pkg
// Shared constants, payload types and helpers for the area bisecting line
// search block.
// ----------------------------------------------------------------------------
package abls_pkg;

   // sizing
   localparam int MAX_SQUARES = 1024;
   localparam int COORD_BITS  = 16;
   localparam int FRAC_BITS   = 20;
   localparam int FIELD_W     = 16;

   localparam int LINE_W      = COORD_BITS + 1 + FRAC_BITS;
   localparam int STORE_LOG   = $clog2(MAX_SQUARES);
   localparam int ADDR_W      = (STORE_LOG > 0) ? STORE_LOG : 1;
   localparam int COUNT_W     = $clog2(MAX_SQUARES + 1);
   localparam int SQUARE_W    = 2 * COORD_BITS;
   localparam int AREA_W      = SQUARE_W + STORE_LOG;
   localparam int PART_TERM_W = COORD_BITS + FRAC_BITS;
   localparam int PART_W      = PART_TERM_W + STORE_LOG;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [FIELD_W-1:0] bottom_edge;
      logic [FIELD_W-1:0] side_length;
      logic               final_square;
   } req_payload_type;

   typedef struct packed {
      logic [LINE_W-1:0] line_height;
      logic              capacity_exceeded;
   } rsp_payload_type;

   // classified square handed from front to back
   typedef struct packed {
      coord_type         bottom;
      coord_type         side;
      logic              last;
      logic              keep;
      logic [ADDR_W-1:0] addr;
   } square_cmd_type;

   // per-square area contribution out of the slice unit
   typedef struct packed {
      logic                   valid;
      logic [SQUARE_W-1:0]    whole;
      logic [PART_TERM_W-1:0] part;
   } slice_term_type;

   // keep the low coordinate bits of an input field
   function automatic coord_type to_coord(input logic [FIELD_W-1:0] value);
      logic [FIELD_W+COORD_BITS-1:0] ext;
      ext = {{COORD_BITS{1'b0}}, value};
      return ext[COORD_BITS-1:0];
   endfunction

endpackage

/* sv/abls_ram.sv */
// ----------------------------------------------------------------------------
// abls_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module abls_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/abls_front.sv */
// ----------------------------------------------------------------------------
// abls_front
// Accepts squares, masks coordinates, decides keep or drop against the store
// capacity, assigns store addresses and queues them for the back end.
// ----------------------------------------------------------------------------
module abls_front
   import abls_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            cmd_valid,
   output square_cmd_type  cmd_data,
   input  logic            cmd_pop
);

   square_cmd_type     queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  fill_ff, fill_in;
   logic [COUNT_W-1:0] kept_ff, kept_in;
   logic               push;
   logic               pop;
   square_cmd_type     cmd_in;

   assign req_ready = fill_ff < QCNT_W'(QUEUE_DEPTH);
   assign push      = req_valid && req_ready;
   assign cmd_valid = fill_ff != '0;
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      cmd_in.bottom = to_coord(req_data.bottom_edge);
      cmd_in.side   = to_coord(req_data.side_length);
      cmd_in.last   = req_data.final_square;
      cmd_in.keep   = kept_ff < COUNT_W'(MAX_SQUARES);
      cmd_in.addr   = kept_ff[ADDR_W-1:0];

      kept_in = kept_ff;
      if (push) begin
         if (cmd_in.last) begin
            kept_in = '0;
         end else if (cmd_in.keep) begin
            kept_in = kept_ff + COUNT_W'(1);
         end
      end

      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      fill_in = fill_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         kept_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         kept_ff   <= kept_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

`ifndef SYNTH
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("square queue over capacity");
`endif

endmodule

/* sv/abls_slice.sv */
// ----------------------------------------------------------------------------
// abls_slice
// Two-stage unit giving one square's area below a trial line: integer and
// fraction rows of the cut, then the two products.
// ----------------------------------------------------------------------------
module abls_slice
   import abls_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  coord_type         bottom,
   input  coord_type         side,
   input  logic [LINE_W-1:0] line,
   output logic              busy,
   output slice_term_type    term
);

   logic [LINE_W-1:0]      base_fx;
   logic [LINE_W-1:0]      top_fx;
   logic [LINE_W-1:0]      cut_fx;
   logic [COORD_BITS:0]    top;
   coord_type              rows_in;
   logic [FRAC_BITS-1:0]   frac_in;

   logic                   a_valid_ff;
   coord_type              a_side_ff;
   coord_type              a_rows_ff;
   logic [FRAC_BITS-1:0]   a_frac_ff;
   logic                   t_valid_ff;
   logic [SQUARE_W-1:0]    t_whole_ff;
   logic [PART_TERM_W-1:0] t_part_ff;

   assign top     = {1'b0, bottom} + {1'b0, side};
   assign base_fx = {1'b0, bottom, {FRAC_BITS{1'b0}}};
   assign top_fx  = {top, {FRAC_BITS{1'b0}}};
   assign cut_fx  = line - base_fx;

   always_comb begin
      priority if (line <= base_fx) begin
         rows_in = '0;
         frac_in = '0;
      end else if (line >= top_fx) begin
         rows_in = side;
         frac_in = '0;
      end else begin
         rows_in = cut_fx[FRAC_BITS +: COORD_BITS];
         frac_in = cut_fx[FRAC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         t_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_side_ff  <= side;
      a_rows_ff  <= rows_in;
      a_frac_ff  <= frac_in;
      t_whole_ff <= SQUARE_W'(a_side_ff) * SQUARE_W'(a_rows_ff);
      t_part_ff  <= PART_TERM_W'(a_side_ff) * PART_TERM_W'(a_frac_ff);
   end

   assign busy       = a_valid_ff || t_valid_ff;
   assign term.valid = t_valid_ff;
   assign term.whole = t_whole_ff;
   assign term.part  = t_part_ff;

endmodule

/* sv/abls_back.sv */
// ----------------------------------------------------------------------------
// abls_back
// Stores kept squares, keeps area and bounds, and on the last square runs the
// bisection over the store, one square per cycle through the read port.
// ----------------------------------------------------------------------------
module abls_back
   import abls_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   input  square_cmd_type  cmd_data,
   output logic            cmd_pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   typedef enum logic [3:0] {
      S_LOAD, S_SETTLE, S_INIT, S_CHECK, S_SWEEP, S_DRAIN, S_SUM, S_DECIDE, S_EMIT
   } state_type;

   state_type           state_ff, state_in;

   // load path
   logic                ld_valid_ff;
   square_cmd_type      ld_ff;
   logic                sq_valid_ff, sq_valid_in;
   logic [SQUARE_W-1:0] sq_ff;
   logic [COORD_BITS:0] ld_top;

   // set statistics
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [AREA_W-1:0]   area_ff, area_in;
   coord_type           lowest_ff, lowest_in;
   logic [COORD_BITS:0] highest_ff, highest_in;
   logic                dropped_ff, dropped_in;

   // search
   logic [LINE_W-1:0]   low_ff, low_in;
   logic [LINE_W-1:0]   high_ff, high_in;
   logic [LINE_W-1:0]   mid_ff, mid_in;
   logic [LINE_W:0]     mid_sum;
   logic [LINE_W-1:0]   init_low;
   logic [LINE_W-1:0]   init_high;
   logic [COUNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic                rd_en;
   logic                rd_vld_ff;
   logic                acc_clear;
   logic                emit;
   logic                below_half;
   logic [AREA_W-1:0]   whole_acc_ff;
   logic [PART_W-1:0]   part_acc_ff;
   logic [AREA_W:0]     below_ff, below_in;
   logic                half_bit_ff, half_bit_in;

   // store and slice unit
   coord_type           rd_bottom;
   coord_type           rd_side;
   logic                slice_busy;
   slice_term_type      term;
   logic                wr_en;

   rsp_payload_type     rsp_data_ff;
   logic                rsp_valid_ff;

   assign cmd_pop = (state_ff == S_LOAD) && cmd_valid;
   assign wr_en   = ld_valid_ff && ld_ff.keep;
   assign ld_top  = {1'b0, ld_ff.bottom} + {1'b0, ld_ff.side};

   abls_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_SQUARES)) u_bottom_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ld_ff.addr),
      .wr_data (ld_ff.bottom),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_bottom)
   );

   abls_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_SQUARES)) u_side_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ld_ff.addr),
      .wr_data (ld_ff.side),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_side)
   );

   abls_slice u_slice (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_vld_ff),
      .bottom   (rd_bottom),
      .side     (rd_side),
      .line     (mid_ff),
      .busy     (slice_busy),
      .term     (term)
   );

   assign mid_sum    = {1'b0, low_ff} + {1'b0, high_ff};
   assign init_low   = LINE_W'({lowest_ff, {FRAC_BITS{1'b0}}});
   assign init_high  = {highest_ff, {FRAC_BITS{1'b0}}};
   assign below_half = {below_ff, half_bit_ff} < (AREA_W + 2)'(area_ff);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      mid_in      = mid_ff;
      rd_cnt_in   = rd_cnt_ff;
      below_in    = below_ff;
      half_bit_in = half_bit_ff;
      acc_clear   = 1'b0;
      rd_en       = 1'b0;
      emit        = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (cmd_valid && cmd_data.last) begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            state_in = S_INIT;
         end
         S_INIT: begin
            low_in   = init_low;
            high_in  = (init_high < init_low) ? init_low : init_high;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            mid_in = mid_sum[LINE_W:1];
            if ((high_ff - low_ff) > LINE_W'(1)) begin
               acc_clear = 1'b1;
               rd_cnt_in = '0;
               state_in  = (count_ff == '0) ? S_SUM : S_SWEEP;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_SWEEP: begin
            rd_en     = 1'b1;
            rd_cnt_in = rd_cnt_ff + COUNT_W'(1);
            if (rd_cnt_in == count_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_vld_ff && !slice_busy) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            below_in    = (AREA_W + 1)'(whole_acc_ff)
                        + (AREA_W + 1)'(part_acc_ff >> FRAC_BITS);
            half_bit_in = part_acc_ff[FRAC_BITS-1];
            state_in    = S_DECIDE;
         end
         S_DECIDE: begin
            if (below_half) begin
               low_in = mid_ff;
            end else begin
               high_in = mid_ff;
            end
            state_in = S_CHECK;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit     = 1'b1;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // set statistics
   always_comb begin
      count_in    = count_ff;
      lowest_in   = lowest_ff;
      highest_in  = highest_ff;
      dropped_in  = dropped_ff;
      area_in     = area_ff;
      sq_valid_in = ld_valid_ff && ld_ff.keep;
      if (emit) begin
         count_in   = '0;
         lowest_in  = '1;
         highest_in = '0;
         dropped_in = 1'b0;
         area_in    = '0;
      end else begin
         if (ld_valid_ff) begin
            if (ld_ff.keep) begin
               count_in = count_ff + COUNT_W'(1);
               if (ld_ff.bottom < lowest_ff) begin
                  lowest_in = ld_ff.bottom;
               end
               if (ld_top > highest_ff) begin
                  highest_in = ld_top;
               end
            end else begin
               dropped_in = 1'b1;
            end
         end
         if (sq_valid_ff) begin
            area_in = area_ff + AREA_W'(sq_ff);
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rsp_valid_ff <= 1'b0;
         ld_valid_ff  <= 1'b0;
         sq_valid_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         count_ff     <= '0;
         area_ff      <= '0;
         lowest_ff    <= '1;
         highest_ff   <= '0;
         dropped_ff   <= 1'b0;
         low_ff       <= '0;
         high_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         ld_valid_ff  <= cmd_pop;
         sq_valid_ff  <= sq_valid_in;
         rd_vld_ff    <= rd_en;
         count_ff     <= count_in;
         area_ff      <= area_in;
         lowest_ff    <= lowest_in;
         highest_ff   <= highest_in;
         dropped_ff   <= dropped_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         if (emit) begin
            rsp_valid_ff                  <= 1'b1;
            rsp_data_ff.line_height       <= mid_ff;
            rsp_data_ff.capacity_exceeded <= dropped_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         ld_ff <= cmd_data;
      end
      sq_ff       <= SQUARE_W'(ld_ff.side) * SQUARE_W'(ld_ff.side);
      mid_ff      <= mid_in;
      rd_cnt_ff   <= rd_cnt_in;
      below_ff    <= below_in;
      half_bit_ff <= half_bit_in;
      if (acc_clear) begin
         whole_acc_ff <= '0;
         part_acc_ff  <= '0;
      end else if (term.valid) begin
         whole_acc_ff <= whole_acc_ff + AREA_W'(term.whole);
         part_acc_ff  <= part_acc_ff + PART_W'(term.part);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      low_ff <= high_ff)
      else $error("search low bound above high bound");

   a_interval_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |=> (high_ff - low_ff) < $past(high_ff - low_ff))
      else $error("bisection step did not narrow the interval");

   a_read_in_set: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_cnt_ff < count_ff))
      else $error("sweep read beyond the squares of the set");
`endif

endmodule

/* sv/area_bisecting_line_search_top.sv */
// ----------------------------------------------------------------------------
// area_bisecting_line_search_top
// Finds the horizontal line that splits the summed area of a set of squares
// in half, by bisection in fixed point with 20 fraction bits.
// ----------------------------------------------------------------------------
// Squares arrive one per req transaction as bottom edge and side length and
// are written into a 1024-entry store; a non-final square is taken every
// cycle as long as the back end keeps up, with a two-entry queue between the
// front end and the store, so up to two squares of the next set are taken
// while a search runs or a result waits on rsp. The square flagged
// final_square closes the set: the settle and init states let the area total
// and bounds catch up, then the block runs one bisection step per candidate
// line, each step sweeping all N kept squares through the store's single read
// port at one square per cycle, so a set costs up to LINE_W (37) steps.
// Overlapping squares count twice. Squares beyond the store capacity are
// dropped and reported through capacity_exceeded on the set's single rsp
// transaction; the square after the final one starts a fresh set. The store
// needs no clearing after reset: only entries written in the current set are
// ever read.
// ----------------------------------------------------------------------------
module area_bisecting_line_search_top
   import abls_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // square input
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   // split line result
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   // classified squares between front end and back end
   logic           cmd_valid;
   logic           cmd_pop;
   square_cmd_type cmd_data;

   // front end: masking, capacity check, store address, queue
   abls_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   // back end: store, statistics, bisection sequencer, result register
   abls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
